### design/lv3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lv3_pkg
// Shared types and constants of the streaming 3x3 local variance block.
// ----------------------------------------------------------------------------
package lv3_pkg;

    // Default frame limits
    localparam int LV3_MAX_WIDTH  = 128;
    localparam int LV3_MAX_HEIGHT = 128;

    // Size register reset value and lower bound
    localparam int LV3_RESET_SIZE = 128;
    localparam int LV3_MIN_SIZE   = 3;

    // Results caused by one pixel at most, and result queue depth
    localparam int LV3_MAX_RUN    = 3;
    localparam int LV3_FIFO_DEPTH = 8;

    // floor(x / 9) = (x * LV3_RECIP9) >> LV3_RECIP_SHIFT for every x below 2**21
    localparam int            LV3_SUM_W       = 20;
    localparam logic [19:0]   LV3_RECIP9      = 20'd932068;
    localparam int            LV3_RECIP_SHIFT = 23;

    // Configuration register indexes
    localparam int LV3_CFG_IDX_W = 1;
    localparam logic [LV3_CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [LV3_CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] mean_value;
    } lv3_in_t;

    typedef struct packed {
        logic signed [16:0] variance;
        logic [6:0]         out_row;
        logic [6:0]         out_col;
        logic               last_of_run;
        logic               end_of_frame;
    } lv3_out_t;

endpackage

### design/local_variance_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_variance_3x3
// Streaming 3x3 local variance over a raster of pixels with supplied means.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one pixel and its mean per beat, in raster
//   order. m_valid/m_ready/m_data return results: mean of squares (on the
//   border the pixel's own square) minus the square of the mean, tagged
//   with row and column. Results of a row come while the next row streams
//   in; the last row is answered as it arrives. One pixel gives zero to
//   three results. A result passes the s1, s2 and s3 registers before it
//   enters the output queue, then shows on m_data at the head of the queue.
//   Throughput: one pixel per cycle while m_ready is high and the pixel
//   gives at most one result; else the output port, one result per cycle,
//   sets the pace. A single line memory (one word per column: two previous
//   pixels and the previous mean) is read and written back once per pixel.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write image_width (index 0) or
//   image_height (index 1), clamped to 3..MAX; any write restarts the frame.
//   Write configuration only while no result is pending.
//   Reset: sizes go to 128 (or MAX), counters to the frame start, the output
//   queue empties. When m_ready stays low the queue fills and s_ready drops.
// ----------------------------------------------------------------------------
module local_variance_3x3
    import lv3_pkg::*;
#(
    parameter int MAX_WIDTH  = LV3_MAX_WIDTH,
    parameter int MAX_HEIGHT = LV3_MAX_HEIGHT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lv3_in_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output lv3_out_t                 m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LV3_CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]               cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;
    localparam int PW = $clog2(LV3_FIFO_DEPTH);
    localparam int RST_W = (MAX_WIDTH < LV3_RESET_SIZE) ? MAX_WIDTH : LV3_RESET_SIZE;
    localparam int RST_H = (MAX_HEIGHT < LV3_RESET_SIZE) ? MAX_HEIGHT : LV3_RESET_SIZE;

    typedef struct packed {
        logic [7:0] mean_prev;
        logic [7:0] pix_prev;
        logic [7:0] pix_old;
    } line_word_t;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic          do_a;
        logic          interior;
        logic          do_b;
        logic          do_c;
        logic          eof;
    } tag_t;

    function automatic int clamp_size(input logic [7:0] v, input int maxv);
        int r;
        r = int'(v);
        if (r < LV3_MIN_SIZE) begin
            r = LV3_MIN_SIZE;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic logic signed [16:0] var_diff(input logic [15:0] a,
                                                    input logic [15:0] b);
        logic [16:0] d;
        d = {1'b0, a} - {1'b0, b};
        return $signed(d);
    endfunction

    // ------------------------------------------------------------------
    // Line memory
    // ------------------------------------------------------------------
    line_word_t line_mem [MAX_WIDTH];
    line_word_t rd_reg;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;

    logic   acc;
    logic   last_col;
    logic   last_row;
    tag_t   tag0;
    logic [1:0] run_len;

    logic v1_reg, v2_reg, v3_reg;
    logic [7:0] s1_pix_reg, s1_mean_reg;
    tag_t       s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [7:0] mean_delay_reg;

    // stage 1 products
    logic [15:0] sq_old, sq_prev, sq_cur, msq_a, msq_b, msq_c;

    logic [17:0] s2_colsum_reg;
    logic [15:0] s2_sq_prev_reg, s2_sq_cur_reg;
    logic [15:0] s2_ma_reg, s2_mb_reg, s2_mc_reg;

    // window: two older column sums and the previous center square
    logic [17:0] wcol0_reg, wcol1_reg;
    logic [15:0] wcent_reg;
    logic [LV3_SUM_W-1:0] sum9;

    logic [LV3_SUM_W-1:0] s3_sum9_reg;
    logic [15:0] s3_center_reg, s3_sq_prev_reg, s3_sq_cur_reg;
    logic [15:0] s3_ma_reg, s3_mb_reg, s3_mc_reg;

    logic [2*LV3_SUM_W-1:0] quot_full;
    logic [15:0] msq_local;

    // output queue
    lv3_out_t    fifo_mem [LV3_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg, res_reg;
    lv3_out_t    res_a, res_b, res_c;
    logic [PW-1:0] pos_b, pos_c;
    logic [1:0]  push_n;
    logic        pop;

    // ------------------------------------------------------------------
    // Stage 0: accept, classify, advance counters
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s_ready   = (res_reg <= (PW+1)'(LV3_FIFO_DEPTH - LV3_MAX_RUN));
    assign acc       = s_valid & s_ready;

    always_comb begin
        last_col      = ({1'b0, col_reg} == width_reg - 1'b1);
        last_row      = ({1'b0, row_reg} == height_reg - 1'b1);
        tag0.row      = row_reg;
        tag0.col      = col_reg;
        tag0.do_a     = (row_reg != '0) && (col_reg != '0);
        tag0.interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        tag0.do_b     = (row_reg != '0) && last_col;
        tag0.do_c     = last_row;
        tag0.eof      = last_col;
        run_len       = {1'b0, tag0.do_a} + {1'b0, tag0.do_b} + {1'b0, tag0.do_c};
        col_next      = col_reg + 1'b1;
        row_next      = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(RST_W);
            height_reg <= HW'(RST_H);
            row_reg    <= '0;
            col_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_reg <= WW'(clamp_size(cfg_data, MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= HW'(clamp_size(cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end else if (acc) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // memory read, registered in rd_reg
    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg <= line_mem[col_reg];
        end
    end

    // write back the column in the cycle after the read: new pixel and mean shift in
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            line_mem[s1_tag_reg.col] <= '{mean_prev: s1_mean_reg,
                                          pix_prev:  s1_pix_reg,
                                          pix_old:   rd_reg.pix_prev};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valids and mean delay
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            mean_delay_reg <= '0;
            wcol0_reg      <= '0;
            wcol1_reg      <= '0;
            wcent_reg      <= '0;
        end else begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cfg_valid) begin
                mean_delay_reg <= '0;
                wcol0_reg      <= '0;
                wcol1_reg      <= '0;
                wcent_reg      <= '0;
            end else begin
                if (v1_reg) begin
                    mean_delay_reg <= rd_reg.mean_prev;
                end
                if (v2_reg) begin
                    wcol0_reg <= wcol1_reg;
                    wcol1_reg <= s2_colsum_reg;
                    wcent_reg <= s2_sq_prev_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares
    // ------------------------------------------------------------------
    always_comb begin
        sq_old  = 16'(rd_reg.pix_old) * 16'(rd_reg.pix_old);
        sq_prev = 16'(rd_reg.pix_prev) * 16'(rd_reg.pix_prev);
        sq_cur  = 16'(s1_pix_reg) * 16'(s1_pix_reg);
        msq_a   = 16'(mean_delay_reg) * 16'(mean_delay_reg);
        msq_b   = 16'(rd_reg.mean_prev) * 16'(rd_reg.mean_prev);
        msq_c   = 16'(s1_mean_reg) * 16'(s1_mean_reg);
    end

    always_ff @(posedge aclk) begin
        s1_pix_reg     <= s_data.pixel_value;
        s1_mean_reg    <= s_data.mean_value;
        s1_tag_reg     <= tag0;
        s2_colsum_reg  <= 18'(sq_old) + 18'(sq_prev) + 18'(sq_cur);
        s2_sq_prev_reg <= sq_prev;
        s2_sq_cur_reg  <= sq_cur;
        s2_ma_reg      <= msq_a;
        s2_mb_reg      <= msq_b;
        s2_mc_reg      <= msq_c;
        s2_tag_reg     <= s1_tag_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: window sum
    // ------------------------------------------------------------------
    assign sum9 = LV3_SUM_W'(wcol0_reg) + LV3_SUM_W'(wcol1_reg) + LV3_SUM_W'(s2_colsum_reg);

    always_ff @(posedge aclk) begin
        s3_sum9_reg    <= sum9;
        s3_center_reg  <= wcent_reg;
        s3_sq_prev_reg <= s2_sq_prev_reg;
        s3_sq_cur_reg  <= s2_sq_cur_reg;
        s3_ma_reg      <= s2_ma_reg;
        s3_mb_reg      <= s2_mb_reg;
        s3_mc_reg      <= s2_mc_reg;
        s3_tag_reg     <= s2_tag_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by nine, subtract, build results
    // ------------------------------------------------------------------
    always_comb begin
        quot_full = (2*LV3_SUM_W)'(s3_sum9_reg) * (2*LV3_SUM_W)'(LV3_RECIP9);
        msq_local = s3_tag_reg.interior ? quot_full[LV3_RECIP_SHIFT +: 16]
                                        : s3_center_reg;

        res_a.variance     = var_diff(msq_local, s3_ma_reg);
        res_a.out_row      = 7'(s3_tag_reg.row - 1'b1);
        res_a.out_col      = 7'(s3_tag_reg.col - 1'b1);
        res_a.last_of_run  = !s3_tag_reg.do_b && !s3_tag_reg.do_c;
        res_a.end_of_frame = 1'b0;

        res_b.variance     = var_diff(s3_sq_prev_reg, s3_mb_reg);
        res_b.out_row      = 7'(s3_tag_reg.row - 1'b1);
        res_b.out_col      = 7'(s3_tag_reg.col);
        res_b.last_of_run  = !s3_tag_reg.do_c;
        res_b.end_of_frame = 1'b0;

        res_c.variance     = var_diff(s3_sq_cur_reg, s3_mc_reg);
        res_c.out_row      = 7'(s3_tag_reg.row);
        res_c.out_col      = 7'(s3_tag_reg.col);
        res_c.last_of_run  = 1'b1;
        res_c.end_of_frame = s3_tag_reg.eof;

        pos_b  = wr_ptr_reg + PW'(s3_tag_reg.do_a);
        pos_c  = pos_b + PW'(s3_tag_reg.do_b);
        push_n = v3_reg ? ({1'b0, s3_tag_reg.do_a} + {1'b0, s3_tag_reg.do_b}
                           + {1'b0, s3_tag_reg.do_c}) : 2'd0;
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    assign m_valid = (cnt_reg != '0);
    assign m_data  = fifo_mem[rd_ptr_reg];
    assign pop     = m_valid & m_ready;

    always_ff @(posedge aclk) begin
        if (v3_reg) begin
            if (s3_tag_reg.do_a) begin
                fifo_mem[wr_ptr_reg] <= res_a;
            end
            if (s3_tag_reg.do_b) begin
                fifo_mem[pos_b] <= res_b;
            end
            if (s3_tag_reg.do_c) begin
                fifo_mem[pos_c] <= res_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            res_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push_n) - (PW+1)'(pop);
            // reserve queue room at accept, release it at pop
            res_reg <= res_reg + (PW+1)'(acc ? run_len : 2'd0) - (PW+1)'(pop);
        end
    end

endmodule

### design/lv3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lv3_checker
// Port-level checks for local_variance_3x3, bound to the top level.
// ----------------------------------------------------------------------------
module lv3_checker
    import lv3_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input lv3_out_t m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset empties the queue and frees the input
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // frame end closes its run
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.end_of_frame |-> m_data.last_of_run)
        else $error("end of frame without last of run");

    // variance stays within the square range
    a_var_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_data.variance) >= -17'sd65025)
                 && ($signed(m_data.variance) <= 17'sd65025))
        else $error("variance out of range");

endmodule

bind local_variance_3x3 lv3_checker u_lv3_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
